>>> rtl/core/assert_macros.svh
// Assertion macros for the top level of the 16-bit SPN cipher.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/spn16_pkg.sv
// Package for the 16-bit SPN cipher: round key type, S-box tables,
// bit permutation and key schedule helpers. No dependencies.
`timescale 1ns / 1ps

package spn16_pkg;

    localparam int BlockWidth = 16;
    localparam int NumRoundKeys = 5;

    typedef logic [BlockWidth-1:0] block_t;
    typedef logic [NumRoundKeys-1:0][BlockWidth-1:0] rkeys_t;

    // Forward S-box.
    function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'd6;
            4'h1: y = 4'd4;
            4'h2: y = 4'd12;
            4'h3: y = 4'd5;
            4'h4: y = 4'd0;
            4'h5: y = 4'd7;
            4'h6: y = 4'd2;
            4'h7: y = 4'd14;
            4'h8: y = 4'd1;
            4'h9: y = 4'd15;
            4'hA: y = 4'd3;
            4'hB: y = 4'd13;
            4'hC: y = 4'd8;
            4'hD: y = 4'd10;
            4'hE: y = 4'd9;
            default: y = 4'd11;
        endcase
        return y;
    endfunction

    // Inverse S-box.
    function automatic logic [3:0] sbox_inv(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'd4;
            4'h1: y = 4'd8;
            4'h2: y = 4'd6;
            4'h3: y = 4'd10;
            4'h4: y = 4'd1;
            4'h5: y = 4'd3;
            4'h6: y = 4'd0;
            4'h7: y = 4'd5;
            4'h8: y = 4'd12;
            4'h9: y = 4'd14;
            4'hA: y = 4'd13;
            4'hB: y = 4'd15;
            4'hC: y = 4'd2;
            4'hD: y = 4'd11;
            4'hE: y = 4'd7;
            default: y = 4'd9;
        endcase
        return y;
    endfunction

    // The permutation transposes the block seen as a 4x4 bit matrix,
    // rows taken from the MSB down. It is its own inverse.
    function automatic block_t bit_perm(input block_t v);
        block_t r;
        r = '0;
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                r[15 - (4 * b + a)] = v[15 - (4 * a + b)];
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl2_byte(input logic [7:0] b);
        return {b[5:0], b[7:6]};
    endfunction

    // Rotate both bytes, then interleave the nibbles as hiH, loH, hiL, loL.
    function automatic block_t next_key(input block_t k);
        logic [7:0] h;
        logic [7:0] l;
        h = rotl2_byte(k[15:8]);
        l = rotl2_byte(k[7:0]);
        return {h[7:4], l[7:4], h[3:0], l[3:0]};
    endfunction

    // The last derivation rotates both bytes and does not regroup.
    function automatic block_t last_key(input block_t k);
        return {rotl2_byte(k[15:8]), rotl2_byte(k[7:0])};
    endfunction

endpackage

>>> rtl/core/spn16_key_sched.sv
// Key register and round key derivation for the 16-bit SPN cipher.
// Depends on spn16_pkg.
`timescale 1ns / 1ps

module spn16_key_sched (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  key_wr_en,
    input  spn16_pkg::block_t     key_wr_data,
    input  logic                  dec,
    output spn16_pkg::rkeys_t     rkeys
);
    import spn16_pkg::*;

    block_t cipher_key_reg;
    block_t cipher_key_next;
    block_t k4, k3, k2, k1, k0;

    always_comb
    begin
        cipher_key_next = key_wr_en ? key_wr_data : cipher_key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg <= '0;
        end
        else
        begin
            cipher_key_reg <= cipher_key_next;
        end
    end

    // The key derivation is rotations and rewiring, so it costs no gates; only the dec selection needs muxes.
    always_comb
    begin
        k4 = cipher_key_reg;
        k3 = next_key(k4);
        k2 = next_key(k3);
        k1 = next_key(k2);
        k0 = last_key(k1);
        if (dec)
        begin
            // Decryption reverses the order and permutes the middle keys.
            rkeys[0] = k4;
            rkeys[1] = bit_perm(k3);
            rkeys[2] = bit_perm(k2);
            rkeys[3] = bit_perm(k1);
            rkeys[4] = k0;
        end
        else
        begin
            rkeys[0] = k0;
            rkeys[1] = k1;
            rkeys[2] = k2;
            rkeys[3] = k3;
            rkeys[4] = k4;
        end
    end

endmodule

>>> rtl/core/spn16_sbox_layer.sv
// One key mixing and substitution layer: key XOR, then four 4-bit S-boxes.
// Depends on spn16_pkg.
`timescale 1ns / 1ps

module spn16_sbox_layer (
    input  spn16_pkg::block_t din,
    input  spn16_pkg::block_t rkey,
    input  logic              dec,
    output spn16_pkg::block_t dout
);
    import spn16_pkg::*;

    block_t mixed;

    always_comb
    begin
        mixed = din ^ rkey;
        for (int n = 0; n < 4; n++)
        begin
            dout[4*n +: 4] = dec ? sbox_inv(mixed[4*n +: 4]) : sbox_fwd(mixed[4*n +: 4]);
        end
    end

endmodule

>>> rtl/core/spn16_datapath.sv
// Four-round SPN network between the input and result registers.
// Depends on spn16_pkg and spn16_sbox_layer.
`timescale 1ns / 1ps

module spn16_datapath (
    input  spn16_pkg::block_t din,
    input  logic              dec,
    input  spn16_pkg::rkeys_t rkeys,
    output spn16_pkg::block_t dout
);
    import spn16_pkg::*;

    block_t s0, s1, s2, s3;

    spn16_sbox_layer u_round0 (.din(din),          .rkey(rkeys[0]), .dec(dec), .dout(s0));
    spn16_sbox_layer u_round1 (.din(bit_perm(s0)), .rkey(rkeys[1]), .dec(dec), .dout(s1));
    spn16_sbox_layer u_round2 (.din(bit_perm(s1)), .rkey(rkeys[2]), .dec(dec), .dout(s2));
    // The fourth round has no permutation; a final whitening XOR follows.
    spn16_sbox_layer u_round3 (.din(bit_perm(s2)), .rkey(rkeys[3]), .dec(dec), .dout(s3));

    assign dout = s3 ^ rkeys[4];

endmodule

>>> rtl/core/spn_block_cipher_16bit_top.sv
// Top level of the 16-bit, four-round SPN block cipher with stream ports.
// Depends on spn16_pkg, spn16_key_sched, spn16_datapath and assert_macros.svh.
//
//   Channel   Direction  Ports                       Contents
//   s_axis    in         tvalid/tready/tdata/tuser   block to encrypt or decrypt
//   m_axis    out        tvalid/tready/tdata         result block
//   key       in         key_wr_en/key_wr_data       16-bit master key write
//
// Each accepted block is held in the input register, then the whole cipher
// network is evaluated in a single pass and captured in the result register.
// One block per cycle is sustained while the output is not stalled.
// Reset clears both valid flags and loads an all-zero master key.
// When the output is stalled, the input register still fills, so one more
// block is taken while a result waits; ready falls only when both are full.
`timescale 1ns / 1ps

module spn_block_cipher_16bit_top (
    input  logic        clk,
    input  logic        rst_n,
    // Master key write; the key must only change while no block is in flight.
    input  logic        key_wr_en,
    input  logic [15:0] key_wr_data,
    // Input transaction.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] data_in
    input  logic        s_axis_tuser,   // [0] req_type: 0 encrypt, 1 decrypt
    // Output transaction.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] data_out
);
    import spn16_pkg::*;

    `include "assert_macros.svh"

    // Input register stage.
    logic   s1_valid_reg, s1_valid_next;
    logic   s1_dec_reg,   s1_dec_next;
    block_t s1_data_reg,  s1_data_next;

    // Result register stage.
    logic   s2_valid_reg, s2_valid_next;
    block_t s2_data_reg,  s2_data_next;

    logic   s2_ready;
    logic   s1_advance;
    logic   in_fire;
    rkeys_t rkeys;
    block_t net_out;

    // The result register can take a new value when it is empty or is
    // being drained in this cycle; the input register likewise.
    assign s2_ready      = !s2_valid_reg || m_axis_tready;
    assign s1_advance    = s1_valid_reg && s2_ready;
    assign s_axis_tready = !s1_valid_reg || s2_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    spn16_key_sched u_key_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_wr_en   (key_wr_en),
        .key_wr_data (key_wr_data),
        .dec         (s1_dec_reg),
        .rkeys       (rkeys)
    );

    spn16_datapath u_datapath (
        .din   (s1_data_reg),
        .dec   (s1_dec_reg),
        .rkeys (rkeys),
        .dout  (net_out)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_dec_next   = s1_dec_reg;
        s1_data_next  = s1_data_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
            s1_dec_next   = s_axis_tuser;
            s1_data_next  = s_axis_tdata;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        s2_data_next  = s2_data_reg;
        if (s1_advance)
        begin
            s2_valid_next = 1'b1;
            s2_data_next  = net_out;
        end
        else if (m_axis_tready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        s1_dec_reg  <= s1_dec_next;
        s1_data_reg <= s1_data_next;
        s2_data_reg <= s2_data_next;
    end

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = s2_data_reg;

    // An accepted transaction is always held in the input register next cycle.
    `ASSERT_NEXT(a_in_captured, in_fire, s1_valid_reg, "accepted block was dropped")

    // A block leaving the input register lands in the result register intact.
    `ASSERT_NEXT(a_result_loaded, s1_advance,
                 s2_valid_reg && (s2_data_reg == $past(net_out)), "result register not loaded")

    // A blocked input register keeps its block.
    `ASSERT_NEXT(a_s1_holds, s1_valid_reg && !s2_ready,
                 s1_valid_reg && $stable(s1_data_reg) && $stable(s1_dec_reg),
                 "stalled block was overwritten")

endmodule
